// ===== rtl/core/lcg_alphanumeric_key_generator_defines.svh =====
// Assertion macros shared by the key generator RTL.
`ifndef LCG_ALPHANUMERIC_KEY_GENERATOR_DEFINES_SVH
`define LCG_ALPHANUMERIC_KEY_GENERATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCGAKG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcgakg: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LCGAKG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcgakg: next-cycle check failed");

`endif

// ===== rtl/core/lcgakg_pkg.sv =====
// Types and constants of the alphanumeric key generator.
package lcgakg_pkg;

    localparam int WORD_W = 64;
    localparam int CHAR_W = 7;
    localparam int CNT_W  = 4;
    localparam int BIT_CNT_W = 6;

    localparam int SHORT_KEY_LEN = 8;
    localparam int LONG_KEY_LEN  = 16;

    localparam int RADIX_DEC   = 10;
    localparam int RADIX_ALPHA = 26;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'd65;

    localparam int ADDR_W = 5;

    typedef enum logic [1:0] {
        REG_MULTIPLIER = 2'd0,
        REG_INCREMENT  = 2'd1,
        REG_MODULUS    = 2'd2,
        REG_SEED_VALUE = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_RUN,
        TOP_HOLD
    } top_state_t;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_MUL,
        ENG_ADD,
        ENG_DIV,
        ENG_DIGIT
    } eng_phase_t;

    typedef struct packed {
        logic              done;
        logic              busy;
        logic [WORD_W-1:0] next_state;
        logic [CHAR_W-1:0] key_char;
    } eng_status_t;

endpackage

// ===== rtl/core/lcgakg_engine.sv =====
// Bit-serial generator step: multiply, add, reduce by the modulus and pick a character.
module lcgakg_engine (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [lcgakg_pkg::WORD_W-1:0]        multiplier,
    input  logic [lcgakg_pkg::WORD_W-1:0]        increment,
    input  logic [lcgakg_pkg::WORD_W-1:0]        modulus,
    input  logic [lcgakg_pkg::WORD_W-1:0]        state_in,
    output lcgakg_pkg::eng_status_t              status
);

    lcgakg_pkg::eng_phase_t                 phase_reg, phase_next;
    logic [lcgakg_pkg::BIT_CNT_W-1:0]       cnt_reg, cnt_next;
    logic [lcgakg_pkg::WORD_W-1:0]          mul_sh_reg, mul_sh_next;
    logic [lcgakg_pkg::WORD_W-1:0]          acc_reg, acc_next;
    logic [lcgakg_pkg::WORD_W-1:0]          rem_reg, rem_next;
    logic [3:0]                             r10_reg, r10_next;
    logic [4:0]                             r26_reg, r26_next;
    logic [lcgakg_pkg::CHAR_W-1:0]          char_reg, char_next;
    logic                                   done_reg, done_next;

    logic [lcgakg_pkg::WORD_W:0]            div_sh;
    logic [lcgakg_pkg::WORD_W-1:0]          div_rem;
    logic [lcgakg_pkg::WORD_W-1:0]          sum;
    logic [4:0]                             t10;
    logic [5:0]                             t26;
    logic [3:0]                             r10_step;
    logic [4:0]                             r26_step;
    logic                                   cnt_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lcgakg_pkg::ENG_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_sh_reg <= mul_sh_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        r10_reg    <= r10_next;
        r26_reg    <= r26_next;
        char_reg   <= char_next;
    end

    always_comb
    begin
        cnt_last = &cnt_reg;
        sum      = acc_reg + increment;

        // One restoring division step; the partial remainder stays below the modulus.
        div_sh = {rem_reg, acc_reg[lcgakg_pkg::WORD_W-1]};
        if (div_sh >= {1'b0, modulus})
        begin
            div_rem = lcgakg_pkg::WORD_W'(div_sh - {1'b0, modulus});
        end
        else
        begin
            div_rem = div_sh[lcgakg_pkg::WORD_W-1:0];
        end

        t10 = {r10_reg, acc_reg[lcgakg_pkg::WORD_W-1]};
        t26 = {r26_reg, acc_reg[lcgakg_pkg::WORD_W-1]};
        if (t10 >= 5'(lcgakg_pkg::RADIX_DEC))
        begin
            r10_step = 4'(t10 - 5'(lcgakg_pkg::RADIX_DEC));
        end
        else
        begin
            r10_step = t10[3:0];
        end
        if (t26 >= 6'(lcgakg_pkg::RADIX_ALPHA))
        begin
            r26_step = 5'(t26 - 6'(lcgakg_pkg::RADIX_ALPHA));
        end
        else
        begin
            r26_step = t26[4:0];
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        mul_sh_next = mul_sh_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        r10_next    = r10_reg;
        r26_next    = r26_reg;
        char_next   = char_reg;
        done_next   = 1'b0;

        case (phase_reg)
            lcgakg_pkg::ENG_IDLE:
            begin
                if (start)
                begin
                    phase_next  = lcgakg_pkg::ENG_MUL;
                    cnt_next    = '0;
                    mul_sh_next = multiplier;
                    acc_next    = '0;
                    rem_next    = state_in;
                end
            end
            lcgakg_pkg::ENG_MUL:
            begin
                // Horner form over the multiplier bits, most significant first, wrapping at 64 bits.
                acc_next = {acc_reg[lcgakg_pkg::WORD_W-2:0], 1'b0}
                           + (mul_sh_reg[lcgakg_pkg::WORD_W-1] ? rem_reg : '0);
                mul_sh_next = {mul_sh_reg[lcgakg_pkg::WORD_W-2:0], 1'b0};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    phase_next = lcgakg_pkg::ENG_ADD;
                end
            end
            lcgakg_pkg::ENG_ADD:
            begin
                acc_next = sum;
                cnt_next = '0;
                r10_next = '0;
                r26_next = '0;
                // A zero modulus stands for 2^64, so the wrapped sum is already the new state.
                if (modulus == '0)
                begin
                    rem_next   = sum;
                    phase_next = lcgakg_pkg::ENG_DIGIT;
                end
                else
                begin
                    rem_next   = '0;
                    phase_next = lcgakg_pkg::ENG_DIV;
                end
            end
            lcgakg_pkg::ENG_DIV:
            begin
                rem_next = div_rem;
                acc_next = {acc_reg[lcgakg_pkg::WORD_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    acc_next   = div_rem;
                    phase_next = lcgakg_pkg::ENG_DIGIT;
                end
            end
            lcgakg_pkg::ENG_DIGIT:
            begin
                r10_next = r10_step;
                r26_next = r26_step;
                acc_next = {acc_reg[lcgakg_pkg::WORD_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    if (rem_reg[0])
                    begin
                        char_next = lcgakg_pkg::CHAR_A + 7'(r26_step);
                    end
                    else
                    begin
                        char_next = lcgakg_pkg::CHAR_ZERO + 7'(r10_step);
                    end
                    done_next  = 1'b1;
                    phase_next = lcgakg_pkg::ENG_IDLE;
                end
            end
            default:
            begin
                phase_next = lcgakg_pkg::ENG_IDLE;
            end
        endcase
    end

    assign status.done       = done_reg;
    assign status.busy       = (phase_reg != lcgakg_pkg::ENG_IDLE);
    assign status.next_state = rem_reg;
    assign status.key_char   = char_reg;

endmodule

// ===== rtl/core/lcg_alphanumeric_key_generator.sv =====
// Top level of the alphanumeric key generator: register port, request control and output register.
// Each accepted request produces a key of 8 characters (long_key low) or 16 characters
// (long_key high), one transaction per character, with last_char set on the final one.
// Every character costs one generator step in a bit-serial engine: a shift-and-add multiply over
// the multiplier bits, an add of the increment, a restoring division by the modulus (skipped when
// the modulus is zero) and the forming of the remainders by 10 and 26, after which the result is
// handed back. The engine works on one request at a time; a new request is taken in the cycle
// after the final character has moved into the output register. Writing seed_value also loads
// the generator state. Registers sit at byte addresses 0, 8, 16 and 24 and are 64 bits wide.
module lcg_alphanumeric_key_generator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [lcgakg_pkg::ADDR_W-1:0]         paddr,
    input  logic [lcgakg_pkg::WORD_W-1:0]         pwdata,
    output logic [lcgakg_pkg::WORD_W-1:0]         prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  long_key,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [lcgakg_pkg::CHAR_W-1:0]         key_char,
    output logic                                  last_char
);

    `include "lcg_alphanumeric_key_generator_defines.svh"

    logic [lcgakg_pkg::WORD_W-1:0]      mult_reg, incr_reg, mod_reg, seed_reg;
    logic [lcgakg_pkg::WORD_W-1:0]      gen_state_reg;
    lcgakg_pkg::top_state_t             state_reg, state_next;
    logic                               long_reg;
    logic [lcgakg_pkg::CNT_W-1:0]       char_cnt_reg;
    logic                               out_valid_reg;
    logic [lcgakg_pkg::CHAR_W-1:0]      key_char_reg;
    logic                               last_char_reg;

    logic                               cfg_write;
    lcgakg_pkg::reg_index_t             cfg_sel;
    logic                               eng_start;
    logic                               load_out;
    logic                               accept_in;
    logic                               out_free;
    logic                               is_last;
    logic [lcgakg_pkg::WORD_W-1:0]      eng_state_in;
    lcgakg_pkg::eng_status_t            eng_stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = lcgakg_pkg::reg_index_t'(paddr[4:3]);

    always_comb
    begin
        case (cfg_sel)
            lcgakg_pkg::REG_MULTIPLIER: prdata = mult_reg;
            lcgakg_pkg::REG_INCREMENT:  prdata = incr_reg;
            lcgakg_pkg::REG_MODULUS:    prdata = mod_reg;
            lcgakg_pkg::REG_SEED_VALUE: prdata = seed_reg;
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg      <= 64'd1;
            incr_reg      <= 64'd0;
            mod_reg       <= '1;
            seed_reg      <= 64'd1;
            gen_state_reg <= 64'd1;
        end
        else
        begin
            if (cfg_write && (cfg_sel == lcgakg_pkg::REG_MULTIPLIER))
            begin
                mult_reg <= pwdata;
            end
            if (cfg_write && (cfg_sel == lcgakg_pkg::REG_INCREMENT))
            begin
                incr_reg <= pwdata;
            end
            if (cfg_write && (cfg_sel == lcgakg_pkg::REG_MODULUS))
            begin
                mod_reg <= pwdata;
            end
            if (cfg_write && (cfg_sel == lcgakg_pkg::REG_SEED_VALUE))
            begin
                seed_reg      <= pwdata;
                gen_state_reg <= pwdata;
            end
            else if (eng_stat.done)
            begin
                gen_state_reg <= eng_stat.next_state;
            end
        end
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign is_last   = (char_cnt_reg == (long_reg ? 4'(lcgakg_pkg::LONG_KEY_LEN - 1)
                                                  : 4'(lcgakg_pkg::SHORT_KEY_LEN - 1)));
    assign accept_in = in_valid && !in_stall;

    // When a character finishes, the state register has not caught up yet, so the
    // next step starts from the engine's own result.
    assign eng_state_in = (state_reg == lcgakg_pkg::TOP_IDLE) ? gen_state_reg
                                                              : eng_stat.next_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcgakg_pkg::TOP_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        eng_start  = 1'b0;
        load_out   = 1'b0;
        in_stall   = (state_reg != lcgakg_pkg::TOP_IDLE);

        case (state_reg)
            lcgakg_pkg::TOP_IDLE:
            begin
                if (in_valid)
                begin
                    eng_start  = 1'b1;
                    state_next = lcgakg_pkg::TOP_RUN;
                end
            end
            lcgakg_pkg::TOP_RUN:
            begin
                if (eng_stat.done)
                begin
                    if (out_free)
                    begin
                        load_out = 1'b1;
                        if (is_last)
                        begin
                            state_next = lcgakg_pkg::TOP_IDLE;
                        end
                        else
                        begin
                            eng_start = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = lcgakg_pkg::TOP_HOLD;
                    end
                end
            end
            lcgakg_pkg::TOP_HOLD:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (is_last)
                    begin
                        state_next = lcgakg_pkg::TOP_IDLE;
                    end
                    else
                    begin
                        eng_start  = 1'b1;
                        state_next = lcgakg_pkg::TOP_RUN;
                    end
                end
            end
            default:
            begin
                state_next = lcgakg_pkg::TOP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            char_cnt_reg  <= '0;
            long_reg      <= 1'b0;
        end
        else
        begin
            if (accept_in)
            begin
                char_cnt_reg <= '0;
                long_reg     <= long_key;
            end
            else if (load_out)
            begin
                char_cnt_reg <= char_cnt_reg + 1'b1;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            key_char_reg  <= eng_stat.key_char;
            last_char_reg <= is_last;
        end
    end

    lcgakg_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (eng_start),
        .multiplier (mult_reg),
        .increment  (incr_reg),
        .modulus    (mod_reg),
        .state_in   (eng_state_in),
        .status     (eng_stat)
    );

    assign out_valid = out_valid_reg;
    assign key_char  = key_char_reg;
    assign last_char = last_char_reg;

    `LCGAKG_ASSERT_NEXT(a_busy_after_accept, accept_in, in_stall)
    `LCGAKG_ASSERT_SAME(a_done_only_in_run, eng_stat.done, state_reg == lcgakg_pkg::TOP_RUN)
    `LCGAKG_ASSERT_SAME(a_start_engine_idle, eng_start, !eng_stat.busy)
    `LCGAKG_ASSERT_NEXT(a_idle_after_last, load_out && is_last, state_reg == lcgakg_pkg::TOP_IDLE)

endmodule
